// File: hw/rtl/hbwm_pkg.sv
package hbwm_pkg;

    localparam int WINDOW_DEPTH_DEF = 30;

    localparam int TS_W       = 32;
    localparam int IVL_W      = 12;
    localparam int HR_W       = 16;
    localparam int STRESS_W   = 7;
    localparam int STATUS_W   = 3;
    localparam int TPM_W      = 16;
    localparam int LOWPCT_W   = 7;
    localparam int HIGHPCT_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = 16;
    localparam int ROOT_W     = 16;

    localparam logic [TPM_W-1:0]     TPM_RST      = 16'd1000;
    localparam logic [IVL_W-1:0]     MIN_IVL_RST  = 12'd400;
    localparam logic [IVL_W-1:0]     MAX_IVL_RST  = 12'd2000;
    localparam logic [LOWPCT_W-1:0]  LOW_PCT_RST  = 7'd75;
    localparam logic [HIGHPCT_W-1:0] HIGH_PCT_RST = 8'd125;

    localparam logic [DIV_N_W-1:0] HR_NUMERATOR = 32'd60000;
    localparam logic [DIV_D_W-1:0] PERCENT_DIV  = 16'd100;
    localparam logic [DIV_D_W-1:0] STRESS_SPAN  = 16'd85;
    localparam logic [IVL_W-1:0]   STRESS_LO    = 12'd15;
    localparam logic [IVL_W-1:0]   STRESS_HI    = 12'd100;
    localparam logic [STRESS_W-1:0] STRESS_MAX  = 7'd100;

    localparam logic OP_BEAT    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TPM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_FIRST       = 3'd0,
        ST_SHORT       = 3'd1,
        ST_RANGE       = 3'd2,
        ST_IMPLAUSIBLE = 3'd3,
        ST_STORED      = 3'd4,
        ST_COMPUTED    = 3'd5,
        ST_NOT_ENOUGH  = 3'd6
    } t_status;

endpackage

// File: hw/rtl/hbwm_ram.sv
module hbwm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/hbwm_div.sv
module hbwm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hbwm_pkg::DIV_N_W-1:0] i_dividend,
    input  logic [hbwm_pkg::DIV_D_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [hbwm_pkg::DIV_N_W-1:0] o_quotient
);
    import hbwm_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_dsr;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {r_rem, r_q[DIV_N_W-1]};
    assign diff    = shifted - {1'b0, r_dsr};
    assign fits    = shifted >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
                r_q   <= {r_q[DIV_N_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: hw/rtl/hbwm_sqrt.sv
module hbwm_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hbwm_pkg::DIV_N_W-1:0] i_value,
    output logic                         o_done,
    output logic [hbwm_pkg::ROOT_W-1:0]  o_root
);
    import hbwm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_v;
    logic [DIV_N_W-1:0] r_res;
    logic [DIV_N_W-1:0] r_bit;
    logic [DIV_N_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= DIV_N_W'(1) << (DIV_N_W - 2);
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// File: hw/rtl/hrv_beat_window_metrics.sv
// Beat-interval window with heart-rate variability metrics. A transaction is taken when
// start is high and busy is low; its single result appears for one cycle with o_done
// and cannot be held off, so it must be captured then. A first beat or a refused
// compute answers in the next cycle; other beats and computes take longer, their time
// set by the shared divider, the root unit and the walks over the interval memory.
// There is no clearing pass after reset.
module hrv_beat_window_metrics #(
    parameter int WINDOW_DEPTH = hbwm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [hbwm_pkg::TS_W-1:0]       i_timestamp,
    input  logic                            i_cfg_we,
    input  logic [hbwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_done,
    output logic [hbwm_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_metrics_valid,
    output logic [hbwm_pkg::IVL_W-1:0]      o_last_interval_ms,
    output logic [hbwm_pkg::HR_W-1:0]       o_heart_rate_bpm,
    output logic [hbwm_pkg::IVL_W-1:0]      o_sdnn_ms,
    output logic [hbwm_pkg::IVL_W-1:0]      o_succ_diff_ms,
    output logic [hbwm_pkg::STRESS_W-1:0]   o_load_index
);
    import hbwm_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int PW    = AW + 1;
    localparam int ACC_W = 2 * IVL_W + CW;
    localparam int PROD_W = 2 * IVL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_DIV,
        S_SUM_RD,
        S_SUM_ACC,
        S_MEAN_DIV,
        S_BAND_MUL,
        S_BAND_DIV,
        S_HR_DIV,
        S_SQ_RD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_VAR_DIV,
        S_ROOT,
        S_STRESS_DIV
    } t_state;

    t_state                r_state;
    logic                  r_op;
    logic [TS_W-1:0]       r_prev;
    logic [TPM_W-1:0]      r_tpm;
    logic [IVL_W-1:0]      r_min_ivl;
    logic [IVL_W-1:0]      r_max_ivl;
    logic [LOWPCT_W-1:0]   r_low_pct;
    logic [HIGHPCT_W-1:0]  r_high_pct;
    logic [AW-1:0]         r_wp;
    logic [CW-1:0]         r_fill;
    logic                  r_enough;
    logic [IVL_W-1:0]      r_last;
    logic [HR_W-1:0]       r_hr;
    logic [IVL_W-1:0]      r_sdnn;
    logic [IVL_W-1:0]      r_rmssd;
    logic [STRESS_W-1:0]   r_stress;
    logic                  r_done;
    t_status               r_status;
    logic [DIV_N_W-1:0]    r_ms;
    logic [IVL_W-1:0]      r_mean;
    logic [DIV_N_W-1:0]    r_lo;
    logic                  r_hi_sel;
    logic                  r_pass;
    logic [AW-1:0]         r_addr;
    logic [CW-1:0]         r_idx;
    logic [ACC_W-1:0]      r_acc;
    logic [IVL_W-1:0]      r_ref_prev;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_dgo;
    logic [DIV_N_W-1:0]    r_dnd;
    logic [DIV_D_W-1:0]    r_dsr;
    logic                  r_sgo;

    logic                  div_done;
    logic [DIV_N_W-1:0]    div_q;
    logic                  sq_done;
    logic [ROOT_W-1:0]     root;
    logic [IVL_W-1:0]      root12;
    logic [IVL_W-1:0]      rdata;
    logic                  ram_we;
    logic [IVL_W-1:0]      ram_wdata;
    logic [IVL_W-1:0]      sq_ref;
    logic [IVL_W-1:0]      sq_d;
    logic [IVL_W-1:0]      m_a;
    logic [IVL_W-1:0]      m_b;
    logic [PROD_W-1:0]     prod;
    logic [PW-1:0]         oldest_sum;
    logic [AW-1:0]         oldest;
    logic [AW-1:0]         addr_next;
    logic                  walk_last;
    logic                  sq_skip;
    logic                  range_bad;
    logic                  store_direct;
    logic                  store_band;

    hbwm_ram #(.WIDTH(IVL_W), .DEPTH(WINDOW_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    hbwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend (r_dnd),
        .i_divisor  (r_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    hbwm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sgo),
        .i_value (div_q),
        .o_done  (sq_done),
        .o_root  (root)
    );

    assign root12 = root[IVL_W-1:0];

    // Oldest entry in arrival order, for the successive-difference walk.
    assign oldest_sum = PW'(r_wp) + PW'(WINDOW_DEPTH) - PW'(r_fill);
    assign oldest     = (oldest_sum >= PW'(WINDOW_DEPTH))
                        ? AW'(oldest_sum - PW'(WINDOW_DEPTH)) : oldest_sum[AW-1:0];
    assign addr_next  = (r_addr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign walk_last  = (r_idx == r_fill - 1'b1);
    assign sq_skip    = r_pass && (r_idx == '0);

    // The one multiplier serves the band limits and the squared differences.
    assign sq_ref = r_pass ? r_ref_prev : r_mean;
    assign sq_d   = (rdata >= sq_ref) ? rdata - sq_ref : sq_ref - rdata;
    always_comb begin
        if (r_state == S_BAND_MUL) begin
            m_a = r_mean;
            m_b = r_hi_sel ? IVL_W'(r_high_pct) : IVL_W'(r_low_pct);
        end else begin
            m_a = sq_d;
            m_b = sq_d;
        end
    end
    assign prod = m_a * m_b;

    assign range_bad    = (div_q < DIV_N_W'(r_min_ivl)) || (div_q > DIV_N_W'(r_max_ivl));
    assign store_direct = (r_state == S_TICK_DIV) && div_done && (div_q != '0)
                          && !range_bad && (r_fill < CW'(3));
    assign store_band   = (r_state == S_BAND_DIV) && div_done && r_hi_sel
                          && !((r_ms < r_lo) || (r_ms > div_q));
    assign ram_we       = store_direct || store_band;
    assign ram_wdata    = (r_state == S_TICK_DIV) ? div_q[IVL_W-1:0] : r_ms[IVL_W-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm      <= TPM_RST;
            r_min_ivl  <= MIN_IVL_RST;
            r_max_ivl  <= MAX_IVL_RST;
            r_low_pct  <= LOW_PCT_RST;
            r_high_pct <= HIGH_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TPM:      r_tpm      <= i_cfg_data[TPM_W-1:0];
                CFG_MIN_IVL:  r_min_ivl  <= i_cfg_data[IVL_W-1:0];
                CFG_MAX_IVL:  r_max_ivl  <= i_cfg_data[IVL_W-1:0];
                CFG_LOW_PCT:  r_low_pct  <= i_cfg_data[LOWPCT_W-1:0];
                CFG_HIGH_PCT: r_high_pct <= i_cfg_data[HIGHPCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_enough <= 1'b0;
            r_last   <= '0;
            r_hr     <= '0;
            r_sdnn   <= '0;
            r_rmssd  <= '0;
            r_stress <= '0;
            r_done   <= 1'b0;
            r_status <= ST_FIRST;
            r_dgo    <= 1'b0;
            r_sgo    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_dgo  <= 1'b0;
            r_sgo  <= 1'b0;

            if (ram_we) begin
                r_last <= ram_wdata;
                r_wp   <= (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill < CW'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_fill != '0) begin
                    r_enough <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_operation;
                        if (i_operation == OP_BEAT) begin
                            r_prev <= i_timestamp;
                            if (r_prev == '0) begin
                                r_status <= ST_FIRST;
                                r_done   <= 1'b1;
                            end else begin
                                r_dnd   <= i_timestamp - r_prev;
                                r_dsr   <= (r_tpm == '0) ? DIV_D_W'(1) : r_tpm;
                                r_dgo   <= 1'b1;
                                r_state <= S_TICK_DIV;
                            end
                        end else if (!r_enough || r_fill < CW'(2)) begin
                            r_status <= ST_NOT_ENOUGH;
                            r_done   <= 1'b1;
                        end else begin
                            r_addr  <= '0;
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_SUM_RD;
                        end
                    end
                end
                S_TICK_DIV: begin
                    if (div_done) begin
                        r_ms <= div_q;
                        if (div_q == '0) begin
                            r_status <= ST_SHORT;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (range_bad) begin
                            r_status <= ST_RANGE;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_fill >= CW'(3)) begin
                            r_addr  <= '0;
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_SUM_RD;
                        end else begin
                            r_status <= ST_STORED;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_acc  <= r_acc + ACC_W'(rdata);
                    r_idx  <= r_idx + 1'b1;
                    r_addr <= addr_next;
                    if (walk_last) begin
                        r_dnd   <= DIV_N_W'(r_acc + ACC_W'(rdata));
                        r_dsr   <= DIV_D_W'(r_fill);
                        r_dgo   <= 1'b1;
                        r_state <= S_MEAN_DIV;
                    end else begin
                        r_state <= S_SUM_RD;
                    end
                end
                S_MEAN_DIV: begin
                    if (div_done) begin
                        r_mean <= div_q[IVL_W-1:0];
                        if (r_op == OP_BEAT) begin
                            r_hi_sel <= 1'b0;
                            r_state  <= S_BAND_MUL;
                        end else if (div_q != '0) begin
                            r_dnd   <= HR_NUMERATOR;
                            r_dsr   <= DIV_D_W'(div_q[IVL_W-1:0]);
                            r_dgo   <= 1'b1;
                            r_state <= S_HR_DIV;
                        end else begin
                            r_pass  <= 1'b0;
                            r_addr  <= '0;
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_SQ_RD;
                        end
                    end
                end
                S_BAND_MUL: begin
                    r_dnd   <= DIV_N_W'(prod);
                    r_dsr   <= PERCENT_DIV;
                    r_dgo   <= 1'b1;
                    r_state <= S_BAND_DIV;
                end
                S_BAND_DIV: begin
                    if (div_done) begin
                        if (!r_hi_sel) begin
                            r_lo     <= div_q;
                            r_hi_sel <= 1'b1;
                            r_state  <= S_BAND_MUL;
                        end else begin
                            r_status <= store_band ? ST_STORED : ST_IMPLAUSIBLE;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_HR_DIV: begin
                    if (div_done) begin
                        r_hr    <= div_q[HR_W-1:0];
                        r_pass  <= 1'b0;
                        r_addr  <= '0;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_SQ_RD;
                    end
                end
                S_SQ_RD: begin
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    r_prod     <= prod;
                    r_ref_prev <= rdata;
                    r_state    <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    if (!sq_skip) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    r_idx  <= r_idx + 1'b1;
                    r_addr <= addr_next;
                    if (walk_last) begin
                        r_dnd   <= DIV_N_W'(r_acc + (sq_skip ? '0 : ACC_W'(r_prod)));
                        r_dsr   <= r_pass ? DIV_D_W'(r_fill - 1'b1) : DIV_D_W'(r_fill);
                        r_dgo   <= 1'b1;
                        r_state <= S_VAR_DIV;
                    end else begin
                        r_state <= S_SQ_RD;
                    end
                end
                S_VAR_DIV: begin
                    if (div_done) begin
                        r_sgo   <= 1'b1;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sq_done) begin
                        if (!r_pass) begin
                            r_sdnn  <= root12;
                            r_pass  <= 1'b1;
                            r_addr  <= oldest;
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= S_SQ_RD;
                        end else begin
                            r_rmssd <= root12;
                            if (root12 >= STRESS_HI) begin
                                r_stress <= '0;
                                r_status <= ST_COMPUTED;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (root12 <= STRESS_LO) begin
                                r_stress <= STRESS_MAX;
                                r_status <= ST_COMPUTED;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_dnd   <= DIV_N_W'(root12 - STRESS_LO) * DIV_N_W'(STRESS_MAX);
                                r_dsr   <= STRESS_SPAN;
                                r_dgo   <= 1'b1;
                                r_state <= S_STRESS_DIV;
                            end
                        end
                    end
                end
                S_STRESS_DIV: begin
                    if (div_done) begin
                        r_stress <= STRESS_MAX - div_q[STRESS_W-1:0];
                        r_status <= ST_COMPUTED;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_metrics_valid    = r_enough;
    assign o_last_interval_ms = r_last;
    assign o_heart_rate_bpm   = r_hr;
    assign o_sdnn_ms          = r_sdnn;
    assign o_succ_diff_ms     = r_rmssd;
    assign o_load_index       = r_stress;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe raised while a transaction is still running");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("window fill count beyond the window depth");

    a_valid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_metrics_valid |-> (r_fill >= CW'(2)))
        else $error("metrics marked valid with fewer than two intervals");

    a_store_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (o_done && o_status == ST_STORED))
        else $error("interval stored without a stored result");

endmodule

// File: tb/tb_hrv_beat_window_metrics.sv
`timescale 1ns / 100ps

module tb_hrv_beat_window_metrics;
    import hbwm_pkg::*;

    localparam int DEPTH     = WINDOW_DEPTH_DEF;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1300;
    localparam int TAIL_WAIT = 600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                valid;
        logic [IVL_W-1:0]    last_ivl;
        logic [HR_W-1:0]     hr;
        logic [IVL_W-1:0]    sdnn;
        logic [IVL_W-1:0]    rmssd;
        logic [STRESS_W-1:0] stress;
    } t_metrics;

    typedef struct {
        logic             op;
        logic [TS_W-1:0]  ts;
        bit               has_fixed;
        t_status          fixed_status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_operation = OP_BEAT;
    logic [TS_W-1:0] i_timestamp = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_done;
    logic [STATUS_W-1:0] o_status;
    logic o_metrics_valid;
    logic [IVL_W-1:0] o_last_interval_ms;
    logic [HR_W-1:0] o_heart_rate_bpm;
    logic [IVL_W-1:0] o_sdnn_ms;
    logic [IVL_W-1:0] o_succ_diff_ms;
    logic [STRESS_W-1:0] o_load_index;

    hrv_beat_window_metrics dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic [TPM_W-1:0]     tpm_reg;
    logic [IVL_W-1:0]     min_reg, max_reg;
    logic [LOWPCT_W-1:0]  low_reg;
    logic [HIGHPCT_W-1:0] high_reg;
    logic [TS_W-1:0]      prev_ts;
    logic [IVL_W-1:0]     ring [DEPTH];
    int unsigned          wptr, fill;
    t_metrics             held;

    t_metrics   pending_metrics[$];
    t_status    fixed_q[$];
    bit         fixed_en_q[$];
    int         n_errors = 0;
    int         n_results = 0;
    int         n_stored = 0;
    int         n_computed = 0;
    int         idle_cycles = 0;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned ring_mean(int unsigned n);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < n; i++) s += ring[i];
        return n ? s / n : 0;
    endfunction

    function automatic t_metrics predict_metrics(logic op, logic [TS_W-1:0] ts);
        t_status st;
        logic [TS_W-1:0] ticks;
        longint unsigned tpm, ms, mean, lo, hi, acc, r;
        longint signed d;
        int unsigned n, oldest;
        t_metrics res;
        if (op == OP_BEAT) begin
            if (prev_ts == 0) begin
                prev_ts = ts;
                st = ST_FIRST;
            end else begin
                ticks = ts - prev_ts;
                prev_ts = ts;
                tpm = (tpm_reg == 0) ? 1 : tpm_reg;
                if (ticks < tpm) st = ST_SHORT;
                else begin
                    ms = ticks / tpm;
                    if (ms < min_reg || ms > max_reg) st = ST_RANGE;
                    else begin
                        st = ST_STORED;
                        if (fill >= 3) begin
                            mean = ring_mean(fill);
                            lo = mean * low_reg / 100;
                            hi = mean * high_reg / 100;
                            if (ms < lo || ms > hi) st = ST_IMPLAUSIBLE;
                        end
                        if (st == ST_STORED) begin
                            held.last_ivl = ms[IVL_W-1:0];
                            ring[wptr] = ms[IVL_W-1:0];
                            wptr = (wptr + 1) % DEPTH;
                            if (fill < DEPTH) fill++;
                            if (fill >= 2) held.valid = 1'b1;
                        end
                    end
                end
            end
        end else if (!held.valid || fill < 2) begin
            st = ST_NOT_ENOUGH;
        end else begin
            st = ST_COMPUTED;
            n = fill;
            mean = ring_mean(n);
            if (mean > 0) held.hr = 16'(60000 / mean);
            acc = 0;
            for (int i = 0; i < n; i++) begin
                d = longint'(ring[i]) - longint'(mean);
                acc += d * d;
            end
            held.sdnn = IVL_W'(int_root(acc / n));
            oldest = (wptr + DEPTH - n) % DEPTH;
            acc = 0;
            for (int i = 0; i + 1 < n; i++) begin
                d = longint'(ring[(oldest + i + 1) % DEPTH])
                    - longint'(ring[(oldest + i) % DEPTH]);
                acc += d * d;
            end
            r = int_root(acc / (n - 1)) & 12'hFFF;
            held.rmssd = IVL_W'(r);
            if (r >= 100) held.stress = 0;
            else if (r <= 15) held.stress = STRESS_MAX;
            else held.stress = STRESS_W'(100 - (r - 15) * 100 / 85);
        end
        res = held;
        res.status = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_metrics exp_m;
        t_metrics got;
        bit       use_fixed;
        t_status  fst;
        if (i_rst_n && o_done) begin
            n_results++;
            got = '{o_status, o_metrics_valid, o_last_interval_ms, o_heart_rate_bpm,
                    o_sdnn_ms, o_succ_diff_ms, o_load_index};
            if (pending_metrics.size() == 0) begin
                $error("result with nothing expected, status %0d", o_status);
                n_errors++;
            end else begin
                exp_m = pending_metrics.pop_front();
                use_fixed = fixed_en_q.pop_front();
                fst = fixed_q.pop_front();
                if (use_fixed && got.status != fst) begin
                    $error("status: table %0d, actual %0d", fst, got.status);
                    n_errors++;
                end
                if (got.status != exp_m.status) begin
                    $error("status: expected %0d, actual %0d", exp_m.status, got.status);
                    n_errors++;
                end
                if (got.valid != exp_m.valid) begin
                    $error("metrics_valid: expected %0d, actual %0d", exp_m.valid, got.valid);
                    n_errors++;
                end
                if (got.last_ivl != exp_m.last_ivl) begin
                    $error("last_interval_ms: expected %0d, actual %0d",
                           exp_m.last_ivl, got.last_ivl);
                    n_errors++;
                end
                if (got.hr != exp_m.hr) begin
                    $error("heart_rate_bpm: expected %0d, actual %0d", exp_m.hr, got.hr);
                    n_errors++;
                end
                if (got.sdnn != exp_m.sdnn) begin
                    $error("sdnn_ms: expected %0d, actual %0d", exp_m.sdnn, got.sdnn);
                    n_errors++;
                end
                if (got.rmssd != exp_m.rmssd) begin
                    $error("succ_diff_ms: expected %0d, actual %0d", exp_m.rmssd, got.rmssd);
                    n_errors++;
                end
                if (got.stress != exp_m.stress) begin
                    $error("load_index: expected %0d, actual %0d", exp_m.stress, got.stress);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TPM:      tpm_reg  = val[TPM_W-1:0];
            CFG_MIN_IVL:  min_reg  = val[IVL_W-1:0];
            CFG_MAX_IVL:  max_reg  = val[IVL_W-1:0];
            CFG_LOW_PCT:  low_reg  = val[LOWPCT_W-1:0];
            CFG_HIGH_PCT: high_reg = val[HIGHPCT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_metrics.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    // With no gap drawn, start stays high so that the next transaction can follow at once.
    task automatic send_item(logic op, logic [TS_W-1:0] ts, bit has_fixed, t_status fst);
        t_metrics m;
        int unsigned n_wait;
        start <= 1'b1;
        i_operation <= op;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        m = predict_metrics(op, ts);
        if (m.status == ST_STORED) n_stored++;
        if (m.status == ST_COMPUTED) n_computed++;
        pending_metrics.push_back(m);
        fixed_en_q.push_back(has_fixed);
        fixed_q.push_back(fst);
        n_wait = $urandom_range(0, 13);
        if (n_wait != 0) begin
            start <= 1'b0;
            repeat (n_wait) @(posedge i_clk);
        end
    endtask

    task automatic set_config(logic [15:0] tpm, logic [11:0] mn, logic [11:0] mx,
                              logic [7:0] lo, logic [7:0] hi);
        write_reg(CFG_TPM, tpm);
        write_reg(CFG_MIN_IVL, 16'(mn));
        write_reg(CFG_MAX_IVL, 16'(mx));
        write_reg(CFG_LOW_PCT, 16'(lo));
        write_reg(CFG_HIGH_PCT, 16'(hi));
    endtask

    t_row dir_rows[] = '{
        '{OP_COMPUTE, 32'd0,          1, ST_NOT_ENOUGH},
        '{OP_BEAT,    32'd0,          1, ST_FIRST},
        '{OP_BEAT,    32'd5000,       1, ST_FIRST},
        '{OP_BEAT,    32'd5500,       1, ST_SHORT},
        '{OP_BEAT,    32'd5600,       1, ST_SHORT},
        '{OP_BEAT,    32'd9000000,    1, ST_RANGE},
        '{OP_BEAT,    32'd9800000,    1, ST_STORED},
        '{OP_COMPUTE, 32'hFFFFFFFF,   1, ST_NOT_ENOUGH},
        '{OP_BEAT,    32'd10600000,   0, ST_STORED},
        '{OP_COMPUTE, 32'd0,          1, ST_COMPUTED},
        '{OP_BEAT,    32'd11450000,   0, ST_STORED},
        '{OP_BEAT,    32'd11700000,   1, ST_RANGE},
        '{OP_BEAT,    32'd12600000,   0, ST_STORED},
        '{OP_BEAT,    32'd14400000,   0, ST_STORED},
        '{OP_COMPUTE, 32'd0,          0, ST_COMPUTED},
        '{OP_BEAT,    32'hFFFF0000,   0, ST_STORED},
        '{OP_BEAT,    32'h000B0000,   0, ST_STORED},
        '{OP_BEAT,    32'hFFFFFFFF,   0, ST_STORED},
        '{OP_COMPUTE, 32'd0,          0, ST_COMPUTED}
    };

    initial begin
        logic [TS_W-1:0] ts;
        int unsigned mode;
        tpm_reg = TPM_RST;
        min_reg = MIN_IVL_RST;
        max_reg = MAX_IVL_RST;
        low_reg = LOW_PCT_RST;
        high_reg = HIGH_PCT_RST;
        prev_ts = '0;
        wptr = 0;
        fill = 0;
        held = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].ts, dir_rows[i].has_fixed,
                      dir_rows[i].fixed_status);
        drain();

        // Zero ticks per ms acts as one; crossed bounds reject every interval.
        set_config(16'd0, 12'd4095, 12'd1, 8'd0, 8'd255);
        send_item(OP_BEAT, 32'd100, 0, ST_FIRST);
        send_item(OP_BEAT, 32'd1100, 1, ST_RANGE);
        drain();
        set_config(16'hFFFF, 12'd1, 12'd4095, 8'd100, 8'd100);
        send_item(OP_BEAT, 32'h10000000, 0, ST_FIRST);
        send_item(OP_BEAT, 32'h20000000, 0, ST_FIRST);
        send_item(OP_COMPUTE, 32'd0, 0, ST_FIRST);
        drain();

        ts = $urandom;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 260 == 0) begin
                drain();
                mode = (k / 260) % 5;
                case (mode)
                    0: set_config(16'd1000, 12'd400, 12'd2000, 8'd75, 8'd125);
                    1: set_config(16'd1, 12'd1, 12'd4095, 8'd0, 8'd255);
                    2: set_config(16'($urandom_range(1, 65535)), 12'($urandom_range(1, 600)),
                                  12'($urandom_range(1500, 4095)),
                                  8'($urandom_range(0, 100)), 8'($urandom_range(100, 255)));
                    3: set_config(16'd65535, 12'd1, 12'd4095, 8'd90, 8'd110);
                    default: set_config(16'($urandom), 12'($urandom),
                                        12'($urandom), 8'($urandom), 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(OP_COMPUTE, $urandom, 0, ST_FIRST);
            end else begin
                case ($urandom_range(0, 9))
                    0: ts = $urandom;
                    1: ts = 32'd0;
                    2: ts = ts + $urandom_range(0, 2 * tpm_reg);
                    default:
                        ts = ts + (tpm_reg == 0 ? 1 : tpm_reg)
                             * $urandom_range(min_reg > 700 ? min_reg : 700,
                                              max_reg < 900 ? (min_reg > 700 ? min_reg : 700)
                                              : 900);
                endcase
                send_item(OP_BEAT, ts, 0, ST_FIRST);
            end
        end
        drain();

        $display("Run covered %0d results: %0d intervals stored, %0d metric computations.",
                 n_results, n_stored, n_computed);
        if (n_errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: hrv_beat_window_metrics.f
hw/rtl/hbwm_pkg.sv
hw/rtl/hbwm_ram.sv
hw/rtl/hbwm_div.sv
hw/rtl/hbwm_sqrt.sv
hw/rtl/hrv_beat_window_metrics.sv
tb/tb_hrv_beat_window_metrics.sv
